FILE: rtl/tlbrr_pkg.sv
// Package for the TLB refill and replacement unit.
// Holds sizes, status and policy codes, register addresses and the
// controller-to-datapath command and status structs. No dependencies.
package tlbrr_pkg;

    // TLB geometry and entry field widths.
    localparam int TLB_ENTRIES = 4;
    localparam int AGE_BITS    = 16;
    localparam int FRAME_BITS  = 8;
    localparam int SLOT_BITS   = $clog2(TLB_ENTRIES);
    localparam int PAGE_BITS   = 12;
    localparam int SIZE_BITS   = 13;
    localparam int FLAG_BITS   = 3;
    localparam int STATUS_BITS = 2;
    localparam int SLOT_FIELD_BITS = 2;

    // Configuration port.
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;
    localparam logic [ADDR_BITS-1:0] ADDR_POLICY = 3'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_SIZE   = 3'd4;

    // Replacement policy codes.
    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_RR  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] STATUS_LOADED       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_OUT_OF_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_RESIDENT = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic step;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } stat_t;

endpackage

FILE: rtl/tlbrr_regs.sv
// Configuration register file of the TLB refill unit (APB-style port).
// Depends on tlbrr_pkg.
module tlbrr_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tlbrr_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [tlbrr_pkg::DATA_BITS-1:0]       pwdata,
    output logic [tlbrr_pkg::DATA_BITS-1:0]       prdata,
    output logic                                  pready,
    output logic                                  policy_mode,
    output logic [tlbrr_pkg::SIZE_BITS-1:0]       page_table_size
);

    logic                              policy_reg;
    logic [tlbrr_pkg::SIZE_BITS-1:0]   size_reg;
    logic                              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= tlbrr_pkg::POLICY_LRU;
            size_reg   <= '0;
        end
        else if (wr_en)
        begin
            if (paddr == tlbrr_pkg::ADDR_POLICY)
            begin
                policy_reg <= pwdata[0];
            end
            if (paddr == tlbrr_pkg::ADDR_SIZE)
            begin
                size_reg <= pwdata[tlbrr_pkg::SIZE_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr)
            tlbrr_pkg::ADDR_POLICY: prdata = tlbrr_pkg::DATA_BITS'(policy_reg);
            tlbrr_pkg::ADDR_SIZE:   prdata = tlbrr_pkg::DATA_BITS'(size_reg);
            default:                prdata = '0;
        endcase
    end

    assign policy_mode     = policy_reg;
    assign page_table_size = size_reg;

endmodule

FILE: rtl/tlbrr_ctrl.sv
// Sequencer of the TLB refill unit: capture, slot scan, commit.
// Depends on tlbrr_pkg.
module tlbrr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tlbrr_pkg::stat_t  stat,
    output tlbrr_pkg::cmd_t   cmd,
    output logic              busy
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.step    = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    // The commit always follows the last scan step.
    a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> $past(cmd.step && stat.scan_last))
        else $error("commit without a completed scan");

    // A captured item always enters the scan on the next cycle.
    a_capture_then_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_SCAN))
        else $error("capture not followed by scan");
`endif

endmodule

FILE: rtl/tlbrr_dp.sv
// Datapath of the TLB refill unit: TLB entry storage, ages, victim pointer,
// the one-slot-per-cycle scan and the result register. Depends on tlbrr_pkg.
module tlbrr_dp
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  tlbrr_pkg::cmd_t                           cmd,
    output tlbrr_pkg::stat_t                          stat,
    input  logic                                      policy_mode,
    input  logic [tlbrr_pkg::SIZE_BITS-1:0]           page_table_size,
    input  logic [tlbrr_pkg::PAGE_BITS-1:0]           page_number,
    input  logic [tlbrr_pkg::FRAME_BITS-1:0]          frame_number,
    input  logic                                      page_resident,
    input  logic                                      read_only,
    input  logic                                      used_bit,
    input  logic                                      dirty_bit,
    output logic                                      done,
    output logic [tlbrr_pkg::STATUS_BITS-1:0]         status,
    output logic [tlbrr_pkg::SLOT_FIELD_BITS-1:0]     slot,
    output logic                                      evicted,
    output logic [tlbrr_pkg::PAGE_BITS-1:0]           evicted_page,
    output logic                                      load_needed
);

    localparam int N = tlbrr_pkg::TLB_ENTRIES;
    localparam int SB = tlbrr_pkg::SLOT_BITS;
    localparam logic [SB-1:0] LAST_IDX = SB'(N - 1);
    localparam logic [tlbrr_pkg::AGE_BITS-1:0] AGE_MAX = '1;

    // TLB entries.
    logic [N-1:0]                       valid_reg;
    logic [tlbrr_pkg::PAGE_BITS-1:0]    page_reg  [N];
    logic [tlbrr_pkg::FRAME_BITS-1:0]   frame_reg [N];
    logic [tlbrr_pkg::FLAG_BITS-1:0]    flags_reg [N];
    logic [tlbrr_pkg::AGE_BITS-1:0]     age_reg   [N];
    logic [SB-1:0]                      ptr_reg;

    // Captured item.
    logic [tlbrr_pkg::PAGE_BITS-1:0]    in_page_reg;
    logic [tlbrr_pkg::FRAME_BITS-1:0]   in_frame_reg;
    logic                               in_res_reg;
    logic [tlbrr_pkg::FLAG_BITS-1:0]    in_flags_reg;

    // Scan state.
    logic [SB-1:0]                      idx_reg;
    logic                               found_reg;
    logic [SB-1:0]                      free_reg;
    logic [SB-1:0]                      best_idx_reg;
    logic [tlbrr_pkg::AGE_BITS-1:0]     best_age_reg;

    // Result register.
    logic                                    done_reg;
    logic [tlbrr_pkg::STATUS_BITS-1:0]       status_reg;
    logic [tlbrr_pkg::SLOT_FIELD_BITS-1:0]   slot_reg;
    logic                                    evicted_reg;
    logic [tlbrr_pkg::PAGE_BITS-1:0]         evicted_page_reg;
    logic                                    load_needed_reg;

    // Commit decision.
    logic                               range_bad;
    logic                               not_res;
    logic                               load_ok;
    logic                               is_lru;
    logic [SB-1:0]                      slot_sel;
    logic [tlbrr_pkg::AGE_BITS-1:0]     cur_age;

    assign stat.scan_last = (idx_reg == LAST_IDX);
    assign cur_age        = age_reg[idx_reg];

    assign is_lru    = (policy_mode == tlbrr_pkg::POLICY_LRU);
    assign range_bad = ({1'b0, in_page_reg} >= page_table_size);
    assign not_res   = (policy_mode == tlbrr_pkg::POLICY_RR) && !in_res_reg;
    assign load_ok   = !range_bad && !not_res;

    always_comb
    begin
        if (found_reg)
        begin
            slot_sel = free_reg;
        end
        else if (is_lru)
        begin
            slot_sel = best_idx_reg;
        end
        else
        begin
            slot_sel = ptr_reg;
        end
    end

    // Item capture, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_page_reg  <= page_number;
            in_frame_reg <= frame_number;
            in_res_reg   <= page_resident;
            in_flags_reg <= {dirty_bit, used_bit, read_only};
        end
    end

    // Scan: one slot a cycle, tracking the first free slot and the oldest one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            free_reg     <= '0;
            best_idx_reg <= '0;
            best_age_reg <= '0;
        end
        else if (cmd.capture)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            if (!stat.scan_last)
            begin
                idx_reg <= idx_reg + SB'(1);
            end
            if (!valid_reg[idx_reg] && !found_reg)
            begin
                found_reg <= 1'b1;
                free_reg  <= idx_reg;
            end
            if ((idx_reg == '0) || (cur_age > best_age_reg))
            begin
                best_age_reg <= cur_age;
                best_idx_reg <= idx_reg;
            end
        end
    end

    // Entry update at commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
            for (int i = 0; i < N; i++)
            begin
                page_reg[i]  <= '0;
                frame_reg[i] <= '0;
                flags_reg[i] <= '0;
                age_reg[i]   <= '0;
            end
        end
        else if (cmd.commit && load_ok)
        begin
            if (is_lru)
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (SB'(i) == slot_sel)
                    begin
                        age_reg[i] <= '0;
                    end
                    else if ((valid_reg[i] || !found_reg) && (age_reg[i] != AGE_MAX))
                    begin
                        age_reg[i] <= age_reg[i] + tlbrr_pkg::AGE_BITS'(1);
                    end
                end
            end
            else if (!found_reg)
            begin
                ptr_reg <= (ptr_reg == LAST_IDX) ? '0 : ptr_reg + SB'(1);
            end
            valid_reg[slot_sel] <= 1'b1;
            page_reg[slot_sel]  <= in_page_reg;
            frame_reg[slot_sel] <= in_frame_reg;
            flags_reg[slot_sel] <= in_flags_reg;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (range_bad)
            begin
                status_reg       <= tlbrr_pkg::STATUS_OUT_OF_RANGE;
                slot_reg         <= '0;
                evicted_reg      <= 1'b0;
                evicted_page_reg <= '0;
                load_needed_reg  <= 1'b0;
            end
            else if (not_res)
            begin
                status_reg       <= tlbrr_pkg::STATUS_NOT_RESIDENT;
                slot_reg         <= '0;
                evicted_reg      <= 1'b0;
                evicted_page_reg <= '0;
                load_needed_reg  <= 1'b0;
            end
            else
            begin
                status_reg       <= tlbrr_pkg::STATUS_LOADED;
                slot_reg         <= tlbrr_pkg::SLOT_FIELD_BITS'(slot_sel);
                evicted_reg      <= !found_reg;
                evicted_page_reg <= found_reg ? '0 : page_reg[slot_sel];
                load_needed_reg  <= is_lru && !in_res_reg;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;
    assign load_needed  = load_needed_reg;

`ifndef SYNTHESIS
    // A result strobe appears only in the cycle after a commit.
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.commit))
        else $error("result strobe without commit");

    // A loaded item always leaves its slot valid.
    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && load_ok) |=> valid_reg[$past(slot_sel)])
        else $error("written slot not valid");
`endif

endmodule

FILE: rtl/tlb_refill_replacement_unit.sv
// Top level of the TLB refill and replacement unit.
// Depends on tlbrr_pkg, tlbrr_regs, tlbrr_ctrl and tlbrr_dp.
//
// Usage: a refill item (page number, frame number and page-table flags) is
// accepted at a rising edge where start is high and busy is low. The unit
// then walks the TLB one slot per cycle, finding the lowest free slot and
// the oldest slot, and then commits the refill. The result
// (status, slot, evicted, evicted_page, load_needed) is shown for exactly
// one cycle with done high; the receiver cannot stall it.
// A new item is not taken until the last one is committed; busy goes low
// again while its result is shown, so the next item may be accepted then.
// The slot scan makes one age compare per cycle.
// Configuration: policy_mode at byte address 0 and page_table_size at byte
// address 4, written through the APB-style port while the unit is idle.
// Reset (rst_n low, asynchronous) clears both registers, all TLB entries,
// their ages and the round-robin pointer; busy and done go low.
// The rejected cases (page out of range, or a non-resident page under
// round-robin) leave the TLB untouched and report zero slot fields.
module tlb_refill_replacement_unit
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic [tlbrr_pkg::PAGE_BITS-1:0]           page_number,
    input  logic [tlbrr_pkg::FRAME_BITS-1:0]          frame_number,
    input  logic                                      page_resident,
    input  logic                                      read_only,
    input  logic                                      used_bit,
    input  logic                                      dirty_bit,
    output logic                                      done,
    output logic [tlbrr_pkg::STATUS_BITS-1:0]         status,
    output logic [tlbrr_pkg::SLOT_FIELD_BITS-1:0]     slot,
    output logic                                      evicted,
    output logic [tlbrr_pkg::PAGE_BITS-1:0]           evicted_page,
    output logic                                      load_needed,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [tlbrr_pkg::ADDR_BITS-1:0]           paddr,
    input  logic [tlbrr_pkg::DATA_BITS-1:0]           pwdata,
    output logic [tlbrr_pkg::DATA_BITS-1:0]           prdata,
    output logic                                      pready
);

    // Configuration values seen by the datapath.
    logic                               policy_mode;
    logic [tlbrr_pkg::SIZE_BITS-1:0]    page_table_size;

    // Controller to datapath command and status.
    tlbrr_pkg::cmd_t                    cmd;
    tlbrr_pkg::stat_t                   stat;

    tlbrr_regs u_regs
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .policy_mode     (policy_mode),
        .page_table_size (page_table_size)
    );

    // The controller takes an item only while idle, then sequences the
    // scan and the commit.
    tlbrr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the TLB, the ages and the pointer, and registers
    // the result for its one-cycle strobe.
    tlbrr_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .policy_mode     (policy_mode),
        .page_table_size (page_table_size),
        .page_number     (page_number),
        .frame_number    (frame_number),
        .page_resident   (page_resident),
        .read_only       (read_only),
        .used_bit        (used_bit),
        .dirty_bit       (dirty_bit),
        .done            (done),
        .status          (status),
        .slot            (slot),
        .evicted         (evicted),
        .evicted_page    (evicted_page),
        .load_needed     (load_needed)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for tlb_refill_replacement_unit: refill items in, one result each.
// Depends on tlbrr_pkg and the unit's RTL; needs no files and no arguments.
module testbench;

    // One refill item as it stands on the input ports.
    typedef struct packed {
        logic [tlbrr_pkg::PAGE_BITS-1:0]  page;
        logic [tlbrr_pkg::FRAME_BITS-1:0] frame;
        logic                             resident;
        logic                             ro;
        logic                             used;
        logic                             dirty;
    } refill_t;

    // One result as it stands on the output ports.
    typedef struct packed {
        logic [tlbrr_pkg::STATUS_BITS-1:0]     status;
        logic [tlbrr_pkg::SLOT_FIELD_BITS-1:0] slot;
        logic                                  evicted;
        logic [tlbrr_pkg::PAGE_BITS-1:0]       evicted_page;
        logic                                  load_needed;
    } outcome_t;

    localparam logic [tlbrr_pkg::AGE_BITS-1:0]  AGE_MAX   = '1;
    localparam logic [tlbrr_pkg::SIZE_BITS-1:0] FULL_SIZE = 13'd4096;

    // Percentages of cycles in which the sender holds back a ready item.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 52;
    localparam int IDLE_LIGHT = 12;

    localparam int PHASE_ITEMS = 200;

    // Every input is known from time zero; the driver and the register
    // tasks take over from there.
    logic                                   clk     = 1'b0;
    logic                                   rst_n   = 1'b0;
    logic                                   start   = 1'b0;
    logic [tlbrr_pkg::PAGE_BITS-1:0]        page_number   = '0;
    logic [tlbrr_pkg::FRAME_BITS-1:0]       frame_number  = '0;
    logic                                   page_resident = 1'b0;
    logic                                   read_only     = 1'b0;
    logic                                   used_bit      = 1'b0;
    logic                                   dirty_bit     = 1'b0;
    logic                                   psel    = 1'b0;
    logic                                   penable = 1'b0;
    logic                                   pwrite  = 1'b0;
    logic [tlbrr_pkg::ADDR_BITS-1:0]        paddr   = '0;
    logic [tlbrr_pkg::DATA_BITS-1:0]        pwdata  = '0;

    logic                                   busy;
    logic                                   done;
    logic [tlbrr_pkg::STATUS_BITS-1:0]      status;
    logic [tlbrr_pkg::SLOT_FIELD_BITS-1:0]  slot;
    logic                                   evicted;
    logic [tlbrr_pkg::PAGE_BITS-1:0]        evicted_page;
    logic                                   load_needed;
    logic [tlbrr_pkg::DATA_BITS-1:0]        prdata;
    logic                                   pready;

    tlb_refill_replacement_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .frame_number  (frame_number),
        .page_resident (page_resident),
        .read_only     (read_only),
        .used_bit      (used_bit),
        .dirty_bit     (dirty_bit),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .evicted       (evicted),
        .evicted_page  (evicted_page),
        .load_needed   (load_needed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // Refill items waiting for the driver, and the results owed by the unit
    // in the order the items were accepted.
    refill_t  pending_refills[$];
    outcome_t owed_results[$];
    refill_t  on_port;
    int       idle_pct        = IDLE_NONE;
    int       items_queued    = 0;
    int       results_checked = 0;
    int       error_count     = 0;

    // Shadow of the unit: configuration and TLB contents. Everything starts
    // at zero, matching the state right after reset.
    logic                               cfg_policy = tlbrr_pkg::POLICY_LRU;
    logic [tlbrr_pkg::SIZE_BITS-1:0]    cfg_size   = '0;
    logic                               tlb_valid [tlbrr_pkg::TLB_ENTRIES] = '{default: 1'b0};
    logic [tlbrr_pkg::PAGE_BITS-1:0]    tlb_page  [tlbrr_pkg::TLB_ENTRIES] = '{default: '0};
    logic [tlbrr_pkg::FRAME_BITS-1:0]   tlb_frame [tlbrr_pkg::TLB_ENTRIES] = '{default: '0};
    logic [tlbrr_pkg::FLAG_BITS-1:0]    tlb_flags [tlbrr_pkg::TLB_ENTRIES] = '{default: '0};
    logic [tlbrr_pkg::AGE_BITS-1:0]     tlb_age   [tlbrr_pkg::TLB_ENTRIES] = '{default: '0};
    int                                 rr_ptr = 0;

    // Applies one accepted refill to the shadow TLB and returns the result
    // the unit must report for it.
    function automatic outcome_t predict_refill(refill_t it);
        outcome_t r;
        int       target;
        bit       have_free;
        r = '0;
        target = 0;
        have_free = 1'b0;
        if ({1'b0, it.page} >= cfg_size)
        begin
            r.status = tlbrr_pkg::STATUS_OUT_OF_RANGE;
        end
        else if (cfg_policy == tlbrr_pkg::POLICY_RR && !it.resident)
        begin
            r.status = tlbrr_pkg::STATUS_NOT_RESIDENT;
        end
        else
        begin
            r.status = tlbrr_pkg::STATUS_LOADED;
            // Scanning downward leaves the lowest invalid slot selected.
            for (int i = tlbrr_pkg::TLB_ENTRIES - 1; i >= 0; i--)
            begin
                if (!tlb_valid[i])
                begin
                    target = i;
                    have_free = 1'b1;
                end
            end
            if (cfg_policy == tlbrr_pkg::POLICY_LRU)
            begin
                // Oldest slot wins; a strict compare keeps the lowest index on a tie.
                if (!have_free)
                begin
                    target = 0;
                    for (int i = 1; i < tlbrr_pkg::TLB_ENTRIES; i++)
                    begin
                        if (tlb_age[i] > tlb_age[target])
                            target = i;
                    end
                end
                // A free-slot fill ages only the valid slots; an eviction ages all.
                for (int i = 0; i < tlbrr_pkg::TLB_ENTRIES; i++)
                begin
                    if ((tlb_valid[i] || !have_free) && tlb_age[i] != AGE_MAX)
                        tlb_age[i] = tlb_age[i] + tlbrr_pkg::AGE_BITS'(1);
                end
                tlb_age[target] = '0;
                r.load_needed = !it.resident;
            end
            else if (!have_free)
            begin
                target = rr_ptr % tlbrr_pkg::TLB_ENTRIES;
                rr_ptr = (target + 1) % tlbrr_pkg::TLB_ENTRIES;
            end
            if (!have_free)
            begin
                r.evicted = 1'b1;
                r.evicted_page = tlb_page[target];
            end
            tlb_valid[target] = 1'b1;
            tlb_page[target]  = it.page;
            tlb_frame[target] = it.frame;
            tlb_flags[target] = {it.dirty, it.used, it.ro};
            r.slot = target[tlbrr_pkg::SLOT_FIELD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Driver. An item is taken at an edge where start is high and busy is
    // low; the prediction is made right then, so the shadow TLB sees items in
    // acceptance order. While idle the data ports carry noise, which the unit
    // must ignore.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                owed_results.push_back(predict_refill(on_port));
            if (!start || !busy)
            begin
                if (pending_refills.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    on_port = pending_refills.pop_front();
                    start         <= 1'b1;
                    page_number   <= on_port.page;
                    frame_number  <= on_port.frame;
                    page_resident <= on_port.resident;
                    read_only     <= on_port.ro;
                    used_bit      <= on_port.used;
                    dirty_bit     <= on_port.dirty;
                end
                else
                begin
                    start         <= 1'b0;
                    page_number   <= tlbrr_pkg::PAGE_BITS'($urandom);
                    frame_number  <= tlbrr_pkg::FRAME_BITS'($urandom);
                    page_resident <= 1'($urandom);
                    read_only     <= 1'($urandom);
                    used_bit      <= 1'($urandom);
                    dirty_bit     <= 1'($urandom);
                end
            end
        end
    end

    // Monitor. Each done strobe is compared with the oldest owed result.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (owed_results.size() == 0)
            begin
                $error("result strobe with no refill outstanding");
                error_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("slot", 32'(want.slot), 32'(slot));
                check_field("evicted", 32'(want.evicted), 32'(evicted));
                check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
                check_field("load_needed", 32'(want.load_needed), 32'(load_needed));
                results_checked++;
            end
        end
    end

    // Register access: a setup phase, then the access phase until pready.
    task automatic reg_write(input logic [tlbrr_pkg::ADDR_BITS-1:0] addr,
                             input logic [tlbrr_pkg::DATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [tlbrr_pkg::ADDR_BITS-1:0] addr,
                            output logic [tlbrr_pkg::DATA_BITS-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes both registers, reads them back, and updates the shadow copy.
    // Only called while no item is in flight.
    task automatic set_config(input logic policy, input logic [tlbrr_pkg::SIZE_BITS-1:0] size);
        logic [tlbrr_pkg::DATA_BITS-1:0] readback;
        reg_write(tlbrr_pkg::ADDR_POLICY, tlbrr_pkg::DATA_BITS'(policy));
        reg_write(tlbrr_pkg::ADDR_SIZE, tlbrr_pkg::DATA_BITS'(size));
        cfg_policy = policy;
        cfg_size   = size;
        reg_read(tlbrr_pkg::ADDR_POLICY, readback);
        check_field("policy_mode readback", 32'(policy), 32'(readback[0]));
        reg_read(tlbrr_pkg::ADDR_SIZE, readback);
        check_field("page_table_size readback", 32'(size),
                    32'(readback[tlbrr_pkg::SIZE_BITS-1:0]));
    endtask

    task automatic queue_refill(input refill_t it);
        pending_refills.push_back(it);
        items_queued++;
    endtask

    // Blocks until every queued item has produced its result, then lets the
    // unit settle.
    task automatic wait_drained();
        while (results_checked < items_queued)
            @(posedge clk);
        repeat (tlbrr_pkg::TLB_ENTRIES + 2) @(posedge clk);
    endtask

    // Random refill shaped by the current table size: mostly legal pages,
    // some at the boundary, some anywhere in the 12-bit space. About a
    // quarter of the entries are not resident.
    function automatic refill_t random_refill();
        refill_t it;
        int      pick;
        pick = $urandom_range(99);
        if (cfg_size == 0 || pick < 10)
            it.page = tlbrr_pkg::PAGE_BITS'($urandom);
        else if (pick < 20)
            it.page = (cfg_size > 4095) ? 12'd4095 :
                      tlbrr_pkg::PAGE_BITS'(32'(cfg_size) - $urandom_range(1, 0));
        else
            it.page = tlbrr_pkg::PAGE_BITS'($urandom_range(32'(cfg_size) - 1, 0));
        it.frame    = tlbrr_pkg::FRAME_BITS'($urandom);
        it.resident = ($urandom_range(3) != 0);
        it.ro       = 1'($urandom);
        it.used     = 1'($urandom);
        it.dirty    = 1'($urandom);
        return it;
    endfunction

    initial
    begin
        logic                            policy;
        logic [tlbrr_pkg::SIZE_BITS-1:0] size;
        int                              gap;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // LRU with the full table: fill all four slots from empty, with the
        // page, frame and flag extremes, then force evictions so that ages
        // decide the victim. A non-resident page still loads here.
        set_config(tlbrr_pkg::POLICY_LRU, FULL_SIZE);
        queue_refill('{12'd0,    8'd0,   1'b1, 1'b0, 1'b0, 1'b0});
        queue_refill('{12'd4095, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1});
        queue_refill('{12'd2048, 8'h55,  1'b0, 1'b1, 1'b0, 1'b1});
        queue_refill('{12'd1,    8'hAA,  1'b1, 1'b0, 1'b1, 1'b0});
        queue_refill('{12'd5,    8'd1,   1'b1, 1'b0, 1'b0, 1'b1});
        queue_refill('{12'd4094, 8'd254, 1'b0, 1'b1, 1'b1, 1'b0});
        queue_refill('{12'd7,    8'd128, 1'b1, 1'b0, 1'b0, 1'b0});
        wait_drained();

        // Round-robin with a full TLB: a non-resident page is turned away,
        // then resident pages walk the pointer all the way around.
        set_config(tlbrr_pkg::POLICY_RR, FULL_SIZE);
        queue_refill('{12'd9,    8'd3,   1'b0, 1'b0, 1'b0, 1'b0});
        queue_refill('{12'd10,   8'd4,   1'b1, 1'b1, 1'b0, 1'b0});
        queue_refill('{12'd11,   8'd5,   1'b1, 1'b0, 1'b1, 1'b0});
        queue_refill('{12'd12,   8'd6,   1'b1, 1'b0, 1'b0, 1'b1});
        queue_refill('{12'd13,   8'd7,   1'b1, 1'b1, 1'b1, 1'b1});
        queue_refill('{12'd4095, 8'd8,   1'b1, 1'b0, 1'b0, 1'b0});
        wait_drained();

        // An empty page table rejects everything, even page zero.
        set_config(tlbrr_pkg::POLICY_LRU, '0);
        queue_refill('{12'd0,    8'd9,   1'b1, 1'b0, 1'b0, 1'b0});
        queue_refill('{12'd4095, 8'd10,  1'b0, 1'b1, 1'b1, 1'b1});
        wait_drained();

        // A one-entry table: only page zero fits, and the range check comes
        // ahead of the residency check.
        set_config(tlbrr_pkg::POLICY_RR, 13'd1);
        queue_refill('{12'd0,    8'd11,  1'b1, 1'b0, 1'b0, 1'b0});
        queue_refill('{12'd1,    8'd12,  1'b0, 1'b0, 1'b0, 1'b0});
        queue_refill('{12'd0,    8'd13,  1'b0, 1'b0, 1'b0, 1'b0});
        wait_drained();

        // Random phases: the policy alternates, the table size rotates among
        // full, tiny and arbitrary, and each idling pattern is run under both
        // policies. The receiver cannot stall, so its stall phase runs with
        // no idling at all.
        for (int ph = 0; ph < 8; ph++)
        begin
            policy = ph[0] ? tlbrr_pkg::POLICY_RR : tlbrr_pkg::POLICY_LRU;
            case (ph % 3)
                0:       size = FULL_SIZE;
                1:       size = tlbrr_pkg::SIZE_BITS'($urandom_range(8, 1));
                default: size = tlbrr_pkg::SIZE_BITS'($urandom_range(4096, 1));
            endcase
            case ((ph >> 1) % 4)
                1:       gap = IDLE_HEAVY;
                3:       gap = IDLE_LIGHT;
                default: gap = IDLE_NONE;
            endcase
            set_config(policy, size);
            idle_pct = gap;
            repeat (PHASE_ITEMS) queue_refill(random_refill());
            wait_drained();
            idle_pct = IDLE_NONE;
        end

        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // 5 ms of simulated time is far beyond any correct run, so reaching it
    // counts as a failure.
    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
